// ----- rtl/tld_pkg.sv -----
// Shared types, codes and constants for the terminal line discipline.
// Used by tld_decode and tty_line_discipline_top; depends on nothing else.
`default_nettype none

package tld_pkg;

    localparam int LINE_DEPTH_DEF = 4096;
    localparam int ERASE_W        = 12;
    localparam int MAX_ERASE      = 4095;

    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DEL    = 8'h7F;
    localparam logic [7:0] CH_WERASE = 8'h17;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    localparam logic [2:0] LMODE_RST = 3'd7;
    localparam logic [2:0] IMODE_RST = 3'd1;
    localparam logic [7:0] INTR_RST  = 8'h03;
    localparam logic [7:0] QUIT_RST  = 8'h1C;
    localparam logic [7:0] SUSP_RST  = 8'h1A;
    localparam logic [7:0] ERASE_RST = 8'h7F;
    localparam logic [7:0] KILL_RST  = 8'h15;
    localparam logic [7:0] EOF_RST   = 8'h04;

    typedef enum logic [2:0] {
        REG_LOCAL_MODE,
        REG_INPUT_MODE,
        REG_INTR_CHAR,
        REG_QUIT_CHAR,
        REG_SUSP_CHAR,
        REG_ERASE_CHAR,
        REG_KILL_CHAR,
        REG_EOF_CHAR
    } cfg_idx_t;

    typedef enum logic [1:0] {
        OP_RX,
        OP_READ,
        OP_FLUSH
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE,
        ST_NODATA,
        ST_REFUSED,
        ST_EOF
    } status_t;

    typedef enum logic [1:0] {
        SIG_NONE,
        SIG_INTR,
        SIG_STOP,
        SIG_QUIT
    } sig_t;

    typedef enum logic [2:0] {
        ECHO_NONE,
        ECHO_CHAR,
        ECHO_CRLF,
        ECHO_ERASE,
        ECHO_CARET
    } echo_t;

    typedef enum logic [2:0] {
        KEY_SIG,
        KEY_EOF,
        KEY_NL,
        KEY_ERASE,
        KEY_KILL,
        KEY_WERASE,
        KEY_ORD
    } key_cls_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_FETCH,
        S_DONE
    } state_t;

    // Classification of one received byte against the current modes
    typedef struct packed {
        key_cls_t   cls;
        sig_t       sig;
        logic       raw_drop;
        logic [7:0] raw_char;
        echo_t      echo_kind;
        logic [7:0] echo_char;
    } key_t;

    typedef struct packed {
        status_t             status;
        logic                dvalid;
        logic [7:0]          dchar;
        logic                line_end;
        sig_t                sig;
        echo_t               echo_kind;
        logic [7:0]          echo_char;
        logic [ERASE_W-1:0]  erase_count;
    } res_t;

endpackage

`default_nettype wire

// ----- rtl/tty_line_discipline_top.sv -----
// Terminal input line discipline. Each request receives a byte, reads one byte of a
// finished line or flushes it; one result per request. A request passes through the states
// EXEC and DONE and waits in DONE until the output register is free; its result is registered
// in res_reg and then in the output register. A read that hands over a byte also passes
// through FETCH. A word erase stays in WALK for each byte it removes, plus one entry when it
// stops on a space, since the erase walks the line store back one entry a cycle through its
// single read port with one shared compare and decrement. The line store is not cleared
// after reset; only bytes of the current line are ever read back. Input is taken again once
// the result has moved to the output register.
// Depends on tld_pkg and tld_decode.
`default_nettype none

module tty_line_discipline_top #(
    parameter int LINE_DEPTH = tld_pkg::LINE_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_char
    input  wire logic [1:0]  s_tuser,   // [1:0] op
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [7:0] deliver_char, [15:8] echo_char,
                                        // [27:16] erase_count, [28] line_pending
    output logic             m_tlast,   // line_end
    output logic [7:0]       m_tuser,   // [1:0] status, [2] deliver_valid,
                                        // [4:3] signal_kind, [7:5] echo_kind
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    import tld_pkg::*;

    localparam int LEN_W = $clog2(LINE_DEPTH);
    localparam int CNT_W = (LEN_W > ERASE_W) ? LEN_W : ERASE_W;
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_DEPTH - 1);

    state_t           state_reg, state_next;
    op_t              op_reg;
    logic [7:0]       ch_reg;
    logic [2:0]       lmode_reg, imode_reg;
    logic [7:0]       intr_reg, quit_reg, susp_reg, erase_reg, kill_reg, eof_reg;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] rpos_reg, rpos_next;
    logic             ready_reg, ready_next;
    logic [LEN_W-1:0] n_reg, n_next;
    logic             phase_reg, phase_next;
    res_t             res_reg, res_next;
    logic             m_valid_reg, m_valid_next;
    res_t             m_res_reg, m_res_next;
    logic             m_pend_reg, m_pend_next;

    logic [7:0]       store_mem [LINE_DEPTH];
    logic [7:0]       mem_q;
    logic             mem_we;
    logic [7:0]       mem_wdata;
    logic [LEN_W-1:0] rd_addr;

    key_t             key;
    logic             canon, echo_en;
    logic             go_walk, go_fetch;
    logic             walk_sp, walk_stop, walk_last, walk_end;
    logic [LEN_W-1:0] n_fin;
    logic [ERASE_W-1:0] sat_len, sat_walk;
    logic             out_free;

    tld_decode u_decode (
        .ch         (ch_reg),
        .local_mode (lmode_reg),
        .input_mode (imode_reg),
        .intr_char  (intr_reg),
        .quit_char  (quit_reg),
        .susp_char  (susp_reg),
        .erase_char (erase_reg),
        .kill_char  (kill_reg),
        .eof_char   (eof_reg),
        .key        (key)
    );

    assign canon    = lmode_reg[1];
    assign echo_en  = lmode_reg[2];
    assign go_walk  = (state_reg == S_EXEC) && (op_reg == OP_RX) && canon && !ready_reg &&
                      (key.cls == KEY_WERASE) && (len_reg != '0);
    assign go_fetch = (state_reg == S_EXEC) && (op_reg == OP_READ) && ready_reg &&
                      (rpos_reg < len_reg);

    // Word erase: skip trailing spaces, then non-spaces, one entry a cycle
    assign walk_sp   = (mem_q == CH_SPACE);
    assign walk_stop = phase_reg && walk_sp;
    assign walk_last = (len_reg == LEN_W'(1));
    assign walk_end  = (state_reg == S_WALK) && (walk_stop || walk_last);
    assign n_fin     = walk_stop ? n_reg : n_reg + LEN_W'(1);

    assign sat_len  = (CNT_W'(len_reg) > CNT_W'(MAX_ERASE)) ? ERASE_W'(MAX_ERASE)
                                                              : ERASE_W'(len_reg);
    assign sat_walk = (CNT_W'(n_fin) > CNT_W'(MAX_ERASE)) ? ERASE_W'(MAX_ERASE)
                                                            : ERASE_W'(n_fin);

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (go_walk)
                    state_next = S_WALK;
                else if (go_fetch)
                    state_next = S_FETCH;
                else
                    state_next = S_DONE;
            end
            S_WALK:
            begin
                if (walk_end)
                    state_next = S_DONE;
            end
            S_FETCH:
                state_next = S_DONE;
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        len_next     = len_reg;
        rpos_next    = rpos_reg;
        ready_next   = ready_reg;
        n_next       = n_reg;
        phase_next   = phase_reg;
        res_next     = res_reg;
        mem_we       = 1'b0;
        mem_wdata    = CH_LF;
        rd_addr      = rpos_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_res_next   = m_res_reg;
        m_pend_next  = m_pend_reg;

        case (state_reg)
            S_EXEC:
            begin
                res_next = '0;
                case (op_reg)
                    OP_RX:
                    begin
                        if (canon)
                        begin
                            if (ready_reg)
                                res_next.status = ST_REFUSED;
                            else
                            begin
                                case (key.cls)
                                    KEY_SIG:
                                    begin
                                        res_next.sig = key.sig;
                                        if (echo_en)
                                            res_next.echo_kind = ECHO_CARET;
                                        if (key.sig == SIG_INTR)
                                        begin
                                            len_next  = '0;
                                            rpos_next = '0;
                                        end
                                    end
                                    KEY_EOF:
                                    begin
                                        if (len_reg == '0)
                                            res_next.status = ST_EOF;
                                        else
                                            ready_next = 1'b1;
                                    end
                                    KEY_NL:
                                    begin
                                        if (len_reg < LEN_MAX)
                                        begin
                                            mem_we   = 1'b1;
                                            len_next = len_reg + LEN_W'(1);
                                        end
                                        if (echo_en)
                                            res_next.echo_kind = ECHO_CRLF;
                                        ready_next = 1'b1;
                                    end
                                    KEY_ERASE:
                                    begin
                                        if (len_reg != '0)
                                        begin
                                            len_next = len_reg - LEN_W'(1);
                                            if (echo_en)
                                            begin
                                                res_next.echo_kind   = ECHO_ERASE;
                                                res_next.erase_count = ERASE_W'(1);
                                            end
                                        end
                                    end
                                    KEY_KILL:
                                    begin
                                        len_next = '0;
                                        if (echo_en && len_reg != '0)
                                        begin
                                            res_next.echo_kind   = ECHO_ERASE;
                                            res_next.erase_count = sat_len;
                                        end
                                    end
                                    KEY_WERASE:
                                    begin
                                        rd_addr    = len_reg - LEN_W'(1);
                                        n_next     = '0;
                                        phase_next = 1'b0;
                                    end
                                    default:
                                    begin
                                        if (len_reg < LEN_MAX)
                                        begin
                                            mem_we             = 1'b1;
                                            mem_wdata          = ch_reg;
                                            len_next           = len_reg + LEN_W'(1);
                                            res_next.echo_kind = key.echo_kind;
                                            res_next.echo_char = key.echo_char;
                                            if (key.echo_kind == ECHO_ERASE)
                                                res_next.erase_count = ERASE_W'(1);
                                        end
                                    end
                                endcase
                            end
                        end
                        else if (key.sig != SIG_NONE)
                            res_next.sig = key.sig;
                        else if (!key.raw_drop)
                        begin
                            res_next.dvalid    = 1'b1;
                            res_next.dchar     = key.raw_char;
                            res_next.echo_kind = key.echo_kind;
                            res_next.echo_char = key.echo_char;
                            if (key.echo_kind == ECHO_ERASE)
                                res_next.erase_count = ERASE_W'(1);
                        end
                    end
                    OP_READ:
                    begin
                        if (!go_fetch)
                        begin
                            res_next.status = ST_NODATA;
                            if (ready_reg)
                            begin
                                len_next   = '0;
                                rpos_next  = '0;
                                ready_next = 1'b0;
                            end
                        end
                    end
                    OP_FLUSH:
                    begin
                        len_next   = '0;
                        rpos_next  = '0;
                        ready_next = 1'b0;
                    end
                    default:
                    begin
                        len_next = len_reg;
                    end
                endcase
            end
            S_WALK:
            begin
                if (!walk_stop)
                begin
                    len_next   = len_reg - LEN_W'(1);
                    n_next     = n_reg + LEN_W'(1);
                    phase_next = phase_reg || !walk_sp;
                    rd_addr    = len_reg - LEN_W'(2);
                end
                if (walk_end && echo_en && n_fin != '0)
                begin
                    res_next.echo_kind   = ECHO_ERASE;
                    res_next.erase_count = sat_walk;
                end
            end
            S_FETCH:
            begin
                res_next.dvalid = 1'b1;
                res_next.dchar  = mem_q;
                rpos_next       = rpos_reg + LEN_W'(1);
                if (rpos_reg + LEN_W'(1) == len_reg)
                begin
                    res_next.line_end = 1'b1;
                    len_next          = '0;
                    rpos_next         = '0;
                    ready_next        = 1'b0;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_res_next   = res_reg;
                    m_pend_next  = ready_reg;
                end
            end
            default:
            begin
                rd_addr = rpos_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            rpos_reg    <= '0;
            ready_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            lmode_reg   <= LMODE_RST;
            imode_reg   <= IMODE_RST;
            intr_reg    <= INTR_RST;
            quit_reg    <= QUIT_RST;
            susp_reg    <= SUSP_RST;
            erase_reg   <= ERASE_RST;
            kill_reg    <= KILL_RST;
            eof_reg     <= EOF_RST;
        end
        else
        begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            rpos_reg    <= rpos_next;
            ready_reg   <= ready_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    REG_LOCAL_MODE: lmode_reg <= cfg_data[2:0];
                    REG_INPUT_MODE: imode_reg <= cfg_data[2:0];
                    REG_INTR_CHAR:  intr_reg  <= cfg_data;
                    REG_QUIT_CHAR:  quit_reg  <= cfg_data;
                    REG_SUSP_CHAR:  susp_reg  <= cfg_data;
                    REG_ERASE_CHAR: erase_reg <= cfg_data;
                    REG_KILL_CHAR:  kill_reg  <= cfg_data;
                    REG_EOF_CHAR:   eof_reg   <= cfg_data;
                    default:        eof_reg   <= eof_reg;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            op_reg <= op_t'(s_tuser);
            ch_reg <= s_tdata;
        end
        n_reg      <= n_next;
        phase_reg  <= phase_next;
        res_reg    <= res_next;
        m_res_reg  <= m_res_next;
        m_pend_reg <= m_pend_next;
    end

    // Line store: one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            store_mem[len_reg] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        mem_q <= store_mem[rd_addr];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tlast  = m_res_reg.line_end;
    assign m_tuser  = {m_res_reg.echo_kind, m_res_reg.sig, m_res_reg.dvalid, m_res_reg.status};
    assign m_tdata  = {3'b000, m_pend_reg, m_res_reg.erase_count, m_res_reg.echo_char,
                       m_res_reg.dchar};

    a_ready_has_line: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (len_reg != '0))
        else $error("finished line with zero length");

    a_read_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |-> (rpos_reg < len_reg))
        else $error("read position beyond finished line");

    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (len_reg != '0))
        else $error("word erase walking an empty line");

    a_deliver_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && m_res_reg.dvalid) |-> (m_res_reg.status == ST_DONE))
        else $error("delivered byte with non-done status");

endmodule

`default_nettype wire

// ----- rtl/tld_decode.sv -----
// Byte classifier: signal keys, line editing keys, CR/LF mapping and byte echo.
// Depends on tld_pkg.
`default_nettype none

module tld_decode (
    input  wire logic [7:0]   ch,
    input  wire logic [2:0]   local_mode,
    input  wire logic [2:0]   input_mode,
    input  wire logic [7:0]   intr_char,
    input  wire logic [7:0]   quit_char,
    input  wire logic [7:0]   susp_char,
    input  wire logic [7:0]   erase_char,
    input  wire logic [7:0]   kill_char,
    input  wire logic [7:0]   eof_char,
    output tld_pkg::key_t     key
);
    import tld_pkg::*;

    logic [7:0] mc;

    always_comb
    begin
        if (ch == CH_CR)
            mc = input_mode[0] ? CH_LF : CH_CR;
        else if (ch == CH_LF)
            mc = input_mode[1] ? CH_CR : CH_LF;
        else
            mc = ch;
    end

    always_comb
    begin
        key           = '0;
        key.sig       = SIG_NONE;
        key.echo_kind = ECHO_NONE;
        key.raw_char  = mc;
        key.raw_drop  = (ch == CH_CR) && input_mode[2];

        if (local_mode[0])
        begin
            if (ch == intr_char)
                key.sig = SIG_INTR;
            else if (ch == susp_char)
                key.sig = SIG_STOP;
            else if (ch == quit_char)
                key.sig = SIG_QUIT;
        end

        // Echo of the (mapped) byte: LF as CR/LF, BS as erase; other bytes below space but tab stay silent
        if (local_mode[2])
        begin
            if (mc == CH_LF)
                key.echo_kind = ECHO_CRLF;
            else if (mc == CH_BS)
                key.echo_kind = ECHO_ERASE;
            else if (mc >= CH_SPACE || mc == CH_TAB)
            begin
                key.echo_kind = ECHO_CHAR;
                key.echo_char = mc;
            end
        end

        if (key.sig != SIG_NONE)
            key.cls = KEY_SIG;
        else if (ch == eof_char)
            key.cls = KEY_EOF;
        else if (ch == CH_CR || ch == CH_LF)
            key.cls = KEY_NL;
        else if (ch == CH_BS || ch == CH_DEL || ch == erase_char)
            key.cls = KEY_ERASE;
        else if (ch == kill_char)
            key.cls = KEY_KILL;
        else if (ch == CH_WERASE)
            key.cls = KEY_WERASE;
        else
            key.cls = KEY_ORD;
    end

endmodule

`default_nettype wire
